>>> sv/pmfp_pkg.sv
// ----------------------------------------------------------------------------
// pmfp_pkg - shared definitions for the power meter frame parser
// Frame constants, status codes and the frame result record that passes from
// the byte parser to the scaling stage.
// ----------------------------------------------------------------------------
package pmfp_pkg;

  // Frame layout
  localparam logic [4:0] LastPos = 5'd23;
  localparam logic [7:0] Hdr0    = 8'h55;
  localparam logic [7:0] Hdr1    = 8'h5A;

  // Gain register defaults (1.0 in Q16.16) and register indexes
  localparam logic [31:0] GainReset   = 32'h0001_0000;
  localparam logic [1:0]  RegVoltGain = 2'd0;
  localparam logic [1:0]  RegCurrGain = 2'd1;
  localparam logic [1:0]  RegPowGain  = 2'd2;

  // Frame check outcome
  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_e;

  // Frame-end result before scaling
  typedef struct packed {
    status_e     status;
    logic        valid;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] power;
  } frame_t;

endpackage

>>> sv/power_meter_frame_parser.sv
// ----------------------------------------------------------------------------
// power_meter_frame_parser - energy meter serial frame parser
// Parses fixed 24-byte meter frames, reports status per frame and scales the
// held voltage, current and power words by programmable Q16.16 gains.
//
//   channel  dir  word fields (lowest bit first)
//   s_axis   in   tdata: rx_byte[7:0]
//   m_axis   out  tuser: frame_status[1:0], reading_valid[2]
//                 tdata: voltage_raw, current_raw, power_raw (16 each),
//                        voltage_scaled, current_scaled, power_scaled (48 each)
//   apb      in   0x0 voltage_gain, 0x4 current_gain, 0x8 power_gain
//
// One input word is taken per cycle; only the frame-end word can stall, and
// only while the frame result register is full and the output register is
// full and not drained. A frame result goes from the parser result register
// to the output register, which holds the three 16x32 gain products. Reset
// clears byte counter and held words, sets gains to 1.0; no clearing pass.
// ----------------------------------------------------------------------------
module power_meter_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // rx_byte[7:0]
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // voltage_raw[15:0], current_raw[31:16], power_raw[47:32],
  // voltage_scaled[95:48], current_scaled[143:96], power_scaled[191:144]
  output logic [191:0] m_axis_tdata,
  // frame_status[1:0], reading_valid[2]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pmfp_pkg::*;

  logic [31:0] volt_gain_q, curr_gain_q, pow_gain_q;
  logic        cfg_wr;

  logic        res_valid;
  logic        res_ready;
  frame_t      res;

  logic [47:0] volt_prod, curr_prod, pow_prod;

  logic        out_valid_q;
  status_e     out_status_q;
  logic        out_rdg_q;
  logic [15:0] out_volt_q, out_curr_q, out_pow_q;
  logic [47:0] out_volt_sc_q, out_curr_sc_q, out_pow_sc_q;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_gain_q <= GainReset;
      curr_gain_q <= GainReset;
      pow_gain_q  <= GainReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegVoltGain: volt_gain_q <= pwdata;
        RegCurrGain: curr_gain_q <= pwdata;
        RegPowGain:  pow_gain_q  <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegVoltGain: prdata = volt_gain_q;
      RegCurrGain: prdata = curr_gain_q;
      RegPowGain:  prdata = pow_gain_q;
      default:     prdata = '0;
    endcase
  end

  // Byte parser and frame checker
  pmfp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (s_axis_tdata),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Scale the held words; held words are zero until the first good frame
  assign volt_prod = 48'(res.voltage) * 48'(volt_gain_q);
  assign curr_prod = 48'(res.current) * 48'(curr_gain_q);
  assign pow_prod  = 48'(res.power)   * 48'(pow_gain_q);

  // Output register: advance when empty or drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_status_q  <= res.status;
      out_rdg_q     <= res.valid;
      out_volt_q    <= res.voltage;
      out_curr_q    <= res.current;
      out_pow_q     <= res.power;
      out_volt_sc_q <= volt_prod;
      out_curr_sc_q <= curr_prod;
      out_pow_sc_q  <= pow_prod;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_rdg_q, out_status_q};
  assign m_axis_tdata  = {out_pow_sc_q, out_curr_sc_q, out_volt_sc_q,
                          out_pow_q, out_curr_q, out_volt_q};

  // No reading yet means all scaled values are zero
  a_zero_scaled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_rdg_q) |->
      (out_volt_sc_q == '0 && out_curr_sc_q == '0 && out_pow_sc_q == '0))
    else $error("scaled value without reading");

  // Status code never takes the unused value
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q == ST_GOOD || out_status_q == ST_BAD_HDR ||
                     out_status_q == ST_BAD_SUM))
    else $error("unused status code");

  // A good frame on the output carries a valid reading
  a_good_reading : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_GOOD) |-> out_rdg_q)
    else $error("good frame without reading flag");

endmodule

>>> sv/pmfp_parse.sv
// ----------------------------------------------------------------------------
// pmfp_parse - byte counter and frame checker
// Counts fixed 24-byte frames, checks header and checksum, stages and holds
// the three measurement words and registers one result per frame end.
// ----------------------------------------------------------------------------
module pmfp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             byte_valid_i,
  output logic             byte_ready_o,
  output logic             res_valid_o,
  output pmfp_pkg::frame_t res_o,
  input  logic             res_ready_i
);
  import pmfp_pkg::*;

  logic [4:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic        first_ok_q, first_ok_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic        have_q, have_d;
  logic [15:0] held_q [3];
  logic [15:0] held_d [3];
  logic [15:0] staged_q [3];
  logic        res_valid_q, res_valid_d;
  frame_t      res_q;

  logic    in_fire;
  logic    is_last;
  status_e status;
  logic    good;

  // Only the frame-end word needs room in the result register
  assign is_last      = (pos_q == LastPos);
  assign byte_ready_o = !is_last || !res_valid_q || res_ready_i;
  assign in_fire      = byte_valid_i && byte_ready_o;

  // Check the frame; a bad header wins over a bad checksum
  always_comb begin
    if (!hdr_ok_q) begin
      status = ST_BAD_HDR;
    end else if (sum_q != byte_i) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_GOOD;
    end
  end
  assign good = (status == ST_GOOD);

  // Next state of the byte counter, checksum, header flags and held words
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    first_ok_d  = first_ok_q;
    hdr_ok_d    = hdr_ok_q;
    have_d      = have_q;
    held_d      = held_q;
    res_valid_d = res_valid_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (in_fire) begin
      if (is_last) begin
        pos_d       = '0;
        res_valid_d = 1'b1;
        if (good) begin
          held_d = staged_q;
          have_d = 1'b1;
        end
      end else begin
        pos_d = pos_q + 5'd1;
        if (pos_q == 5'd0) begin
          first_ok_d = (byte_i == Hdr0);
          sum_d      = byte_i;
        end else begin
          sum_d = sum_q + byte_i;
        end
        if (pos_q == 5'd1) begin
          hdr_ok_d = first_ok_q && (byte_i == Hdr1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      first_ok_q  <= 1'b0;
      hdr_ok_q    <= 1'b0;
      have_q      <= 1'b0;
      held_q      <= '{default: '0};
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      first_ok_q  <= first_ok_d;
      hdr_ok_q    <= hdr_ok_d;
      have_q      <= have_d;
      held_q      <= held_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Stage the big-endian words from bytes 4 to 9
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      case (pos_q)
        5'd4:    staged_q[0][15:8] <= byte_i;
        5'd5:    staged_q[0][7:0]  <= byte_i;
        5'd6:    staged_q[1][15:8] <= byte_i;
        5'd7:    staged_q[1][7:0]  <= byte_i;
        5'd8:    staged_q[2][15:8] <= byte_i;
        5'd9:    staged_q[2][7:0]  <= byte_i;
        default: ;
      endcase
    end
  end

  // Capture the frame-end result
  always_ff @(posedge clk_i) begin
    if (in_fire && is_last) begin
      res_q.status  <= status;
      res_q.valid   <= have_q || good;
      res_q.voltage <= good ? staged_q[0] : held_q[0];
      res_q.current <= good ? staged_q[1] : held_q[1];
      res_q.power   <= good ? staged_q[2] : held_q[2];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The byte counter never runs past the frame end
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("byte position beyond frame end");

  // A new result appears only after the frame-end word
  a_res_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(in_fire && is_last))
    else $error("result without frame end");

  // The reading flag is sticky
  a_have_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |=> have_q)
    else $error("reading flag dropped");

  // A good frame always reports a valid reading
  a_good_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status == ST_GOOD) |-> res_q.valid)
    else $error("good frame without valid reading");

endmodule
